[rtl/nfct2_pkg.sv]
package nfct2_pkg;

  localparam int unsigned DataPages = 135;
  localparam int unsigned SigPages = 8;
  localparam int unsigned TotalPages = DataPages + SigPages;
  localparam int unsigned MaxFastReadPages = 64;
  localparam int unsigned PageAw = $clog2(TotalPages);

  localparam logic [7:0] CmdGetVersion = 8'h60;
  localparam logic [7:0] CmdRead = 8'h30;
  localparam logic [7:0] CmdHalt = 8'h50;
  localparam logic [7:0] CmdReadSig = 8'h3c;
  localparam logic [7:0] CmdPwdAuth = 8'h1b;
  localparam logic [7:0] CmdFastRead = 8'h3a;
  localparam logic [7:0] CmdWrite = 8'ha2;
  localparam logic [7:0] CmdCompatWrite = 8'ha0;

  localparam logic [7:0] PagePwd = 8'd133;
  localparam logic [7:0] PagePack = 8'd134;
  localparam logic [7:0] PageLock = 8'd2;

  localparam logic [31:0] AckCode = 32'hA;
  localparam logic [31:0] NakCode = 32'h0;
  localparam logic [31:0] Version0 = 32'h02040400;
  localparam logic [31:0] Version1 = 32'h03110001;
  localparam logic [15:0] PackReset = 16'h8080;

  typedef enum logic [1:0] {
    FuncFrame = 2'd0,
    FuncFieldLost = 2'd1,
    FuncLinkErr = 2'd2,
    FuncLoad = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KindData = 2'd0,
    KindCode = 2'd1,
    KindSleep = 2'd2,
    KindSave = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  cmd;
    logic [7:0]  arg_first;
    logic [7:0]  arg_second;
    logic [31:0] payload;
    logic [7:0]  load_page;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] data;
    logic [2:0]  bytes_valid;
    logic        last;
    logic        dirty;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StWait,
    StEmit,
    StHold
  } state_e;

  // Datapath operations.
  typedef enum logic [2:0] {
    OpNone,
    OpLatch,
    OpRdPage,
    OpEmitPage,
    OpEmitFixed
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       fixed_last;
    logic [1:0] fixed_kind;
    logic [31:0] fixed_data;
    logic [2:0] fixed_bytes;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
    logic out_busy;
  } dp_stat_t;

endpackage

[rtl/nfc_type2_tag_command_engine.sv]
// NFC Type 2 tag command engine: one input word (frame, field loss, link error or page
// load) is taken when the engine is idle and answered with zero to 64 result words on
// the output channel, the last flagged by last. Each word carries the dirty mark as it
// stands after the input. Page data comes from a 143-word page store with a registered
// read, so each page word is read into a register before it is emitted. Page store
// contents are undefined until loaded; there is no clearing pass. The PACK reply
// register pack_q is written on its own cfg channel, which is always ready.
module nfc_type2_tag_command_engine import nfct2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] pack_q;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [7:0]  rd_first;
  logic [6:0]  rd_count;
  logic        rd_wrap;
  logic        wr_en;
  logic [7:0]  wr_page;
  logic [31:0] wr_data;
  logic        wr_keep_low;
  logic        dirty;

  assign cfg_ready_o = 1'b1;

  // Hold the PACK reply register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_q <= PackReset;
    end else if (cfg_valid_i) begin
      pack_q <= cfg_data_i;
    end
  end

  nfct2_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .pack_i(pack_q), .stat_i(stat), .cmd_o(cmd),
    .rd_first_o(rd_first), .rd_count_o(rd_count), .rd_wrap_o(rd_wrap),
    .wr_en_o(wr_en), .wr_page_o(wr_page), .wr_data_o(wr_data),
    .wr_keep_low_o(wr_keep_low), .dirty_o(dirty)
  );

  nfct2_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .rd_first_i(rd_first), .rd_count_i(rd_count), .rd_wrap_i(rd_wrap),
    .wr_en_i(wr_en), .wr_page_i(wr_page), .wr_data_i(wr_data),
    .wr_keep_low_i(wr_keep_low), .dirty_i(dirty),
    .out_ready_i, .out_valid_o, .out_word_o, .stat_o(stat)
  );

  // Never accept a new word while a result other than the last still waits.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o || out_ready_i || out_word_o.last)
    else $error("input taken mid reply");

  a_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind != KindData |-> out_word_o.bytes_valid == 3'd0)
    else $error("bytes_valid on code word");

endmodule

[rtl/nfct2_datapath.sv]
module nfct2_datapath import nfct2_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dp_cmd_t   cmd_i,
  input  logic [7:0] rd_first_i,
  input  logic [6:0] rd_count_i,
  input  logic      rd_wrap_i,
  input  logic      wr_en_i,
  input  logic [7:0] wr_page_i,
  input  logic [31:0] wr_data_i,
  input  logic      wr_keep_low_i,
  input  logic      dirty_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_word_t out_word_o,
  output dp_stat_t  stat_o
);

  logic [31:0] mem_q [TotalPages];
  logic [31:0] rd_q;
  logic [7:0]  addr_q, addr_d;
  logic [6:0]  left_q, left_d;
  logic        wrap_q;
  logic        valid_q, valid_d;
  out_word_t   word_q, word_d;

  // Page 2 write keeps its low half; needs the old page, read ahead.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_page_i < 8'(TotalPages)) begin
      if (wr_keep_low_i) begin
        mem_q[wr_page_i[PageAw-1:0]] <= {wr_data_i[31:16], rd_q[15:0]};
      end else begin
        mem_q[wr_page_i[PageAw-1:0]] <= wr_data_i;
      end
    end
    rd_q <= mem_q[addr_q[PageAw-1:0]];
  end

  always_comb begin
    addr_d = addr_q;
    left_d = left_q;
    if (cmd_i.op == OpLatch) begin
      addr_d = rd_first_i;
      left_d = rd_count_i;
    end else if (cmd_i.op == OpEmitPage) begin
      left_d = left_q - 7'd1;
      if (wrap_q && addr_q == 8'(DataPages - 1)) begin
        addr_d = 8'd0;
      end else begin
        addr_d = addr_q + 8'd1;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    word_d = word_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (cmd_i.op == OpEmitPage) begin
      valid_d = 1'b1;
      word_d = '{kind: KindData, data: rd_q, bytes_valid: 3'd4,
                 last: (left_q == 7'd1), dirty: dirty_i};
    end else if (cmd_i.op == OpEmitFixed) begin
      valid_d = 1'b1;
      word_d = '{kind: cmd_i.fixed_kind, data: cmd_i.fixed_data,
                 bytes_valid: cmd_i.fixed_bytes, last: cmd_i.fixed_last, dirty: dirty_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      addr_q <= '0;
      left_q <= '0;
      wrap_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      addr_q <= addr_d;
      left_q <= left_d;
      if (cmd_i.op == OpLatch) begin
        wrap_q <= rd_wrap_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o = valid_q;
  assign out_word_o = word_q;
  assign stat_o = '{more: (left_q > 7'd1), out_busy: valid_q && !out_ready_i};

endmodule

[rtl/nfct2_ctrl.sv]
module nfct2_ctrl import nfct2_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  input  logic [15:0] pack_i,
  input  dp_stat_t   stat_i,
  output dp_cmd_t    cmd_o,
  output logic [7:0] rd_first_o,
  output logic [6:0] rd_count_o,
  output logic       rd_wrap_o,
  output logic       wr_en_o,
  output logic [7:0] wr_page_o,
  output logic [31:0] wr_data_o,
  output logic       wr_keep_low_o,
  output logic       dirty_o
);

  state_e      state_q, state_d;
  logic        pend_q, pend_d;
  logic [7:0]  pend_page_q, pend_page_d;
  logic        dirty_q, dirty_d;
  logic        acc;
  logic [8:0]  span;
  // Fixed single or double word reply, decoded at accept.
  logic        fix_q, fix_d;
  logic        two_q, two_d;
  logic        page_q, page_d;
  dp_cmd_t     fx0_q, fx0_d;
  logic        wr_q, wr_d;
  logic [7:0]  wpg_q, wpg_d;
  logic [31:0] wdat_q, wdat_d;
  logic        wlow_q, wlow_d;

  assign acc = in_valid_i && in_ready_o;
  assign span = {1'b0, in_word_i.arg_second} - {1'b0, in_word_i.arg_first} + 9'd1;

  always_comb begin
    pend_d = pend_q;
    pend_page_d = pend_page_q;
    dirty_d = dirty_q;
    fix_d = 1'b0;
    two_d = 1'b0;
    page_d = 1'b0;
    fx0_d = '{op: OpEmitFixed, fixed_last: 1'b1, fixed_kind: KindCode,
              fixed_data: NakCode, fixed_bytes: 3'd0};
    wr_d = 1'b0;
    wpg_d = in_word_i.arg_first;
    wdat_d = in_word_i.payload;
    wlow_d = 1'b0;
    rd_first_o = in_word_i.arg_first;
    rd_count_o = 7'd4;
    rd_wrap_o = 1'b1;
    if (acc) begin
      case (in_word_i.func)
        FuncFieldLost: begin
          if (dirty_q) begin
            dirty_d = 1'b0;
            fix_d = 1'b1;
            fx0_d.fixed_kind = KindSave;
          end
        end
        FuncLinkErr: begin
          fix_d = 1'b1;
          fx0_d.fixed_kind = KindSleep;
        end
        FuncLoad: begin
          wr_d = 1'b1;
          wpg_d = in_word_i.load_page;
          if (in_word_i.load_page < 8'(TotalPages)) dirty_d = 1'b0;
        end
        default: begin
          fix_d = 1'b1;
          if (pend_q) begin
            pend_d = 1'b0;
            pend_page_d = 8'd0;
            wpg_d = pend_page_q;
            if (pend_page_q < 8'(TotalPages)) begin
              wr_d = 1'b1;
              dirty_d = 1'b1;
              fx0_d.fixed_data = AckCode;
            end
          end else begin
            case (in_word_i.cmd)
              CmdGetVersion: begin
                two_d = 1'b1;
                fx0_d = '{op: OpEmitFixed, fixed_last: 1'b0, fixed_kind: KindData,
                          fixed_data: Version0, fixed_bytes: 3'd4};
              end
              CmdRead: begin
                fix_d = 1'b0;
                page_d = in_word_i.arg_first < 8'(DataPages);
              end
              CmdHalt: fx0_d.fixed_kind = KindSleep;
              CmdReadSig: begin
                fix_d = 1'b0;
                page_d = 1'b1;
                rd_first_o = 8'(DataPages);
                rd_count_o = 7'(SigPages);
                rd_wrap_o = 1'b0;
              end
              CmdPwdAuth: begin
                fx0_d.fixed_kind = KindData;
                fx0_d.fixed_data = {16'd0, pack_i};
                fx0_d.fixed_bytes = 3'd2;
              end
              CmdFastRead: begin
                rd_count_o = span[6:0];
                rd_wrap_o = 1'b0;
                if (!(in_word_i.arg_first > in_word_i.arg_second ||
                      in_word_i.arg_second >= 8'(DataPages) ||
                      span > 9'(MaxFastReadPages))) begin
                  fix_d = 1'b0;
                  page_d = 1'b1;
                end
              end
              CmdWrite: begin
                if (in_word_i.arg_first < 8'(DataPages)) begin
                  dirty_d = 1'b1;
                  fx0_d.fixed_data = AckCode;
                  wr_d = in_word_i.arg_first != PagePwd && in_word_i.arg_first != PagePack;
                  wlow_d = in_word_i.arg_first == PageLock;
                  rd_first_o = PageLock;
                end
              end
              CmdCompatWrite: begin
                if (in_word_i.arg_first < 8'(TotalPages)) begin
                  pend_d = 1'b1;
                  pend_page_d = in_word_i.arg_first;
                  fx0_d.fixed_data = AckCode;
                end
              end
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (acc) state_d = StRead;
      StRead: state_d = StWait;
      StWait: state_d = StEmit;
      StEmit: begin
        if (!stat_i.out_busy) begin
          if (page_q && stat_i.more) state_d = StWait;
          else if (fix_q && two_q) state_d = StEmit;
          else state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o = (state_q == StIdle);
    cmd_o = '{op: OpNone, fixed_last: 1'b0, fixed_kind: KindData,
              fixed_data: '0, fixed_bytes: 3'd0};
    if (acc) cmd_o.op = OpLatch;
    wr_en_o = (state_q == StWait) && wr_q;
    wr_page_o = wpg_q;
    wr_data_o = wdat_q;
    wr_keep_low_o = wlow_q;
    if (state_q == StEmit && !stat_i.out_busy) begin
      if (page_q) begin
        cmd_o.op = OpEmitPage;
      end else if (fix_q) begin
        cmd_o = fx0_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pend_q <= 1'b0;
      pend_page_q <= '0;
      dirty_q <= 1'b0;
      fix_q <= 1'b0;
      two_q <= 1'b0;
      page_q <= 1'b0;
      wr_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
      pend_page_q <= pend_page_d;
      dirty_q <= dirty_d;
      if (acc) begin
        fix_q <= fix_d;
        two_q <= two_d;
        page_q <= page_d;
        wr_q <= wr_d;
      end else if (state_q == StEmit && !stat_i.out_busy && fix_q) begin
        // second version word follows the first
        if (two_q) two_q <= 1'b0;
        else fix_q <= 1'b0;
      end
      if (state_q == StEmit && !stat_i.out_busy && page_q && !stat_i.more) begin
        page_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      fx0_q <= fx0_d;
      wpg_q <= wpg_d;
      wdat_q <= wdat_d;
      wlow_q <= wlow_d;
    end else if (state_q == StEmit && !stat_i.out_busy && fix_q && two_q) begin
      fx0_q.fixed_data <= Version1;
      fx0_q.fixed_last <= 1'b1;
    end
  end

  assign dirty_o = dirty_q;

endmodule
